// ----- rtl/sync_key_hunter_core_defines.svh -----
// Assertion macros shared by the checker of the sync key hunter.
`ifndef SYNC_KEY_HUNTER_CORE_DEFINES_SVH
`define SYNC_KEY_HUNTER_CORE_DEFINES_SVH

// Property checked while out of reset.
`define SKH_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sync key hunter check failed");

// Property checked on every edge, reset included.
`define SKH_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("sync key hunter check failed");

`endif

// ----- rtl/skh_pkg.sv -----
package skh_pkg;

    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 1;
    localparam int KEY_LEN_W  = 4;
    localparam int SKIP_W     = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_KEY     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_KEY_LEN = 1'd1;

    typedef enum logic [1:0] {
        OP_DATA  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2
    } t_op;

    typedef struct packed {
        t_op        operation;
        logic [7:0] data_byte;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]        out_byte;
        logic              is_key_replay;
        logic              last_of_run;
        logic [SKIP_W-1:0] skipped_bytes;
    } t_out_beat;

    // Outcome of one accepted input beat, handed from hunter to emitter
    typedef struct packed {
        logic                 pass;
        logic                 sync;
        logic [7:0]           data_byte;
        logic [SKIP_W-1:0]    skip;
        logic [KEY_LEN_W-1:0] len;
    } t_hunt_evt;

endpackage

// ----- rtl/skh_in_if.sv -----
interface skh_in_if;
    logic               valid;
    logic               ready;
    skh_pkg::t_in_beat  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/skh_out_if.sv -----
interface skh_out_if;
    logic               valid;
    logic               ready;
    skh_pkg::t_out_beat payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/sync_key_hunter_core.sv -----
// Channel   Dir  Beat payload                                        Handshake
// i_in      in   operation, data_byte                                valid/ready
// o_out     out  out_byte, is_key_replay, last_of_run, skipped_bytes valid/ready
// i_cfg_*   in   index 0 sync_key, index 1 sync_key_length           write enable
//
// One input beat is taken per cycle unless a stall or replay holds it; its result sits in the
// output register the next cycle. A sync match replays sync_key_length key bytes (up to
// MAX_KEY_BYTES); the emitter's replay counter holds the input off until its last byte leaves.
// Reset is synchronous, active low, and clears the hunt state and both config registers.
// A stalled output holds its beat and the input; input is taken in the cycle a last beat leaves.
module sync_key_hunter_core #(
    parameter int MAX_KEY_BYTES = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    skh_in_if.sink                          i_in,
    skh_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [skh_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [skh_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    localparam int LEN_W = $clog2(MAX_KEY_BYTES + 1);
    localparam int KEY_W = 8 * MAX_KEY_BYTES;

    logic [KEY_W-1:0]              r_sync_key;
    logic [skh_pkg::KEY_LEN_W-1:0] r_sync_key_len;
    logic [LEN_W-1:0]              w_len;
    logic                          w_in_ready;
    logic                          w_fire;
    skh_pkg::t_hunt_evt            w_evt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_key     <= '0;
            r_sync_key_len <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                skh_pkg::CFG_SYNC_KEY:     r_sync_key     <= i_cfg_data[KEY_W-1:0];
                skh_pkg::CFG_SYNC_KEY_LEN: r_sync_key_len <= i_cfg_data[skh_pkg::KEY_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp an oversized length to the key store
    assign w_len = (r_sync_key_len > skh_pkg::KEY_LEN_W'(MAX_KEY_BYTES))
                 ? LEN_W'(MAX_KEY_BYTES) : r_sync_key_len[LEN_W-1:0];

    assign w_fire     = i_in.valid && w_in_ready;
    assign i_in.ready = w_in_ready;

    skh_hunter #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_hunter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_beat  (i_in.payload),
        .i_key   (r_sync_key),
        .i_len   (w_len),
        .o_evt   (w_evt)
    );

    skh_emitter #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_emitter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_evt       (w_evt),
        .i_key       (r_sync_key),
        .i_out_ready (o_out.ready),
        .o_in_ready  (w_in_ready),
        .o_valid     (o_out.valid),
        .o_beat      (o_out.payload)
    );

endmodule

// ----- rtl/skh_hunter.sv -----
module skh_hunter #(
    parameter int MAX_KEY_BYTES = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_fire,
    input  skh_pkg::t_in_beat                      i_beat,
    input  logic [8*MAX_KEY_BYTES-1:0]             i_key,
    input  logic [$clog2(MAX_KEY_BYTES+1)-1:0]     i_len,
    output skh_pkg::t_hunt_evt                     o_evt
);
    localparam int LEN_W = $clog2(MAX_KEY_BYTES + 1);
    localparam int IDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

    logic                        r_enabled, n_enabled;
    logic                        r_hunting, n_hunting;
    logic [LEN_W-1:0]            r_ofs, n_ofs;
    logic [skh_pkg::SKIP_W-1:0]  r_skip, n_skip;

    logic [7:0]                  w_key_byte;
    logic [LEN_W-1:0]            w_next_ofs;
    logic [skh_pkg::SKIP_W-1:0]  w_skip_inc;
    logic [skh_pkg::SKIP_W-1:0]  w_skip_sync;

    // The stored offset always stays below MAX_KEY_BYTES, so it indexes the key directly
    assign w_key_byte  = i_key[r_ofs[IDX_W-1:0]*8 +: 8];
    assign w_next_ofs  = (i_beat.data_byte == w_key_byte) ? LEN_W'(r_ofs + 1'b1) : '0;
    assign w_skip_inc  = r_skip + skh_pkg::SKIP_W'(1);
    assign w_skip_sync = w_skip_inc - skh_pkg::SKIP_W'(i_len);

    always_comb begin
        n_enabled       = r_enabled;
        n_hunting       = r_hunting;
        n_ofs           = r_ofs;
        n_skip          = r_skip;
        o_evt           = '0;
        o_evt.data_byte = i_beat.data_byte;
        o_evt.skip      = w_skip_sync;
        o_evt.len       = skh_pkg::KEY_LEN_W'(i_len);
        if (i_fire) begin
            case (i_beat.operation)
                skh_pkg::OP_START: begin
                    if (!r_enabled) begin
                        n_enabled = 1'b1;
                        n_hunting = (i_len != '0);
                        if (i_len != '0) begin
                            n_ofs  = '0;
                            n_skip = '0;
                        end
                    end
                end
                skh_pkg::OP_STOP: begin
                    n_enabled = 1'b0;
                    n_hunting = 1'b0;
                end
                skh_pkg::OP_DATA: begin
                    if (r_enabled) begin
                        if (r_hunting && (i_len == '0)) begin
                            // length cleared mid-hunt: drop out and pass this byte
                            n_hunting  = 1'b0;
                            n_ofs      = '0;
                            o_evt.pass = 1'b1;
                        end else if (r_hunting) begin
                            n_skip = w_skip_inc;
                            n_ofs  = w_next_ofs;
                            if (w_next_ofs >= i_len) begin
                                n_skip     = w_skip_sync;
                                n_hunting  = 1'b0;
                                n_ofs      = '0;
                                o_evt.sync = 1'b1;
                            end
                        end else begin
                            o_evt.pass = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b0;
            r_hunting <= 1'b0;
            r_ofs     <= '0;
            r_skip    <= '0;
        end else begin
            r_enabled <= n_enabled;
            r_hunting <= n_hunting;
            r_ofs     <= n_ofs;
            r_skip    <= n_skip;
        end
    end

endmodule

// ----- rtl/skh_emitter.sv -----
module skh_emitter #(
    parameter int MAX_KEY_BYTES = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  skh_pkg::t_hunt_evt          i_evt,
    input  logic [8*MAX_KEY_BYTES-1:0]  i_key,
    input  logic                        i_out_ready,
    output logic                        o_in_ready,
    output logic                        o_valid,
    output skh_pkg::t_out_beat          o_beat
);
    localparam int LEN_W = $clog2(MAX_KEY_BYTES + 1);
    localparam int IDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

    logic                r_valid, n_valid;
    skh_pkg::t_out_beat  r_beat, n_beat;
    logic [LEN_W-1:0]    r_idx, n_idx;
    logic [LEN_W-1:0]    r_len, n_len;
    logic                w_take;
    logic [LEN_W-1:0]    w_evt_len;

    assign w_take     = r_valid && i_out_ready;
    assign w_evt_len  = i_evt.len[LEN_W-1:0];
    // Take a new beat when nothing is held, or when the held one is the last of its run and leaves now
    assign o_in_ready = !r_valid || (i_out_ready && r_beat.last_of_run);

    always_comb begin
        n_valid = r_valid;
        n_beat  = r_beat;
        n_idx   = r_idx;
        n_len   = r_len;
        if (w_take) begin
            if (r_beat.last_of_run) begin
                n_valid = 1'b0;
            end else begin
                // advance the key replay by one byte
                n_beat.out_byte    = i_key[r_idx[IDX_W-1:0]*8 +: 8];
                n_beat.last_of_run = (LEN_W'(r_idx + 1'b1) == r_len);
                n_idx              = LEN_W'(r_idx + 1'b1);
            end
        end
        if (i_fire && (i_evt.pass || i_evt.sync)) begin
            n_valid              = 1'b1;
            n_beat.out_byte      = i_evt.pass ? i_evt.data_byte : i_key[7:0];
            n_beat.is_key_replay = i_evt.sync;
            n_beat.last_of_run   = i_evt.pass || (w_evt_len == LEN_W'(1));
            n_beat.skipped_bytes = i_evt.pass ? '0 : i_evt.skip;
            n_idx                = LEN_W'(1);
            n_len                = w_evt_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_beat <= n_beat;
        r_idx  <= n_idx;
        r_len  <= n_len;
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

// ----- rtl/skh_checker.sv -----
`include "sync_key_hunter_core_defines.svh"

module skh_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input skh_pkg::t_out_beat i_out_beat
);
    // a waiting beat stays offered
    `SKH_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid)
    // a passed byte is a run of one and reports no skipped count
    `SKH_ASSERT(a_pass_single, i_clk, i_rst_n,
        i_out_valid && !i_out_beat.is_key_replay |->
        i_out_beat.last_of_run && (i_out_beat.skipped_bytes == '0))
    // no new beat enters while a replay still has bytes to go
    `SKH_ASSERT(a_replay_blocks_in, i_clk, i_rst_n,
        i_out_valid && !i_out_beat.last_of_run |-> !i_in_ready)
    // replay bytes follow back to back with one skipped count
    `SKH_ASSERT(a_replay_run, i_clk, i_rst_n,
        i_out_valid && i_out_ready && i_out_beat.is_key_replay && !i_out_beat.last_of_run
        |=> i_out_valid && i_out_beat.is_key_replay && $stable(i_out_beat.skipped_bytes))
    // output is empty straight after reset
    `SKH_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid)

endmodule

bind sync_key_hunter_core skh_checker u_skh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_beat  (o_out.payload)
);
